### design/dqph_pkg.sv
// dqph_pkg: shared constants, codes and item types for the dns question name
// parser and hasher; used by every module under design/

package dqph_pkg;

  localparam int MAX_NAME_BYTES = 256;
  localparam int MAX_LABELS     = 64;

  localparam int CHARS_W  = $clog2(MAX_NAME_BYTES);
  localparam int LABELS_W = $clog2(MAX_LABELS + 1);
  localparam int LEFT_W   = 6;
  localparam int HASH_W   = 64;

  localparam logic [CHARS_W-1:0]  CHAR_CAP   = CHARS_W'(MAX_NAME_BYTES - 1);
  localparam logic [LABELS_W-1:0] LABEL_CAP  = LABELS_W'(MAX_LABELS);
  localparam logic [HASH_W-1:0]   HASH_SEED  = 64'd5381;
  localparam logic [7:0]          LABEL_MAX  = 8'd63;
  localparam logic [7:0]          DOT_CHAR   = 8'h2E;

  // parser phase codes
  localparam logic [1:0] PH_LEN   = 2'd0;
  localparam logic [1:0] PH_LABEL = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  // stop reasons
  localparam logic [1:0] STOP_ZERO  = 2'd0;
  localparam logic [1:0] STOP_LONG  = 2'd1;
  localparam logic [1:0] STOP_END   = 2'd2;
  localparam logic [1:0] STOP_LIMIT = 2'd3;

  // result kinds
  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       packet_end;
  } in_item_t;

  typedef struct packed {
    logic              item_kind;
    logic [7:0]        name_char;
    logic [7:0]        name_length;
    logic [HASH_W-1:0] name_hash;
    logic [1:0]        stop_reason;
    logic              last_of_run;
  } out_item_t;

  // up to two results made by one byte, in order
  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } res_pair_t;

endpackage

### design/dqph_core.sv
// dqph_core: parser state and per-byte decode, hash and summary logic
// depends on dqph_pkg

module dqph_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  dqph_pkg::in_item_t  item,
  output dqph_pkg::res_pair_t res
);

  logic [1:0]                    phase_r, phase_nxt;
  logic [dqph_pkg::LEFT_W-1:0]   left_r, left_nxt;
  logic [dqph_pkg::CHARS_W-1:0]  chars_r, chars_nxt;
  logic [dqph_pkg::LABELS_W-1:0] labels_r, labels_nxt;
  logic [dqph_pkg::HASH_W-1:0]   hash_r, hash_nxt;
  logic                          frozen_r, frozen_nxt;

  logic [7:0]                    b;
  logic                          endp;
  logic                          is_len, is_lab, len_ok;
  logic [7:0]                    c;
  logic                          want_emit, emitted, finish;
  logic [1:0]                    reason;
  logic [dqph_pkg::LABELS_W-1:0] labels1;
  logic [dqph_pkg::CHARS_W-1:0]  chars1;
  logic [dqph_pkg::HASH_W-1:0]   hash1;
  logic                          frozen1, lim;
  logic [dqph_pkg::LEFT_W-1:0]   left_dec;
  dqph_pkg::out_item_t           ci, si;

  always_comb begin
    b      = item.in_byte;
    endp   = item.packet_end;
    is_len = (phase_r == dqph_pkg::PH_LEN);
    is_lab = (phase_r == dqph_pkg::PH_LABEL);
    len_ok = (b != 8'd0) && (b <= dqph_pkg::LABEL_MAX);

    labels1 = labels_r + dqph_pkg::LABELS_W'(is_len && len_ok);
    lim     = (labels1 >= dqph_pkg::LABEL_CAP);

    // a dot goes in front of every label after the first
    c         = is_lab ? b : dqph_pkg::DOT_CHAR;
    want_emit = is_lab || (is_len && len_ok && (chars_r != '0));
    emitted   = want_emit && (chars_r < dqph_pkg::CHAR_CAP);

    chars1  = chars_r + dqph_pkg::CHARS_W'(emitted);
    frozen1 = frozen_r || (emitted && (c == 8'd0));
    if (emitted && !frozen_r && (c != 8'd0)) begin
      hash1 = (hash_r << 5) + hash_r + dqph_pkg::HASH_W'(c);
    end else begin
      hash1 = hash_r;
    end

    left_dec = (left_r != '0) ? left_r - dqph_pkg::LEFT_W'(1) : '0;

    finish     = 1'b0;
    reason     = dqph_pkg::STOP_ZERO;
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    case (phase_r)
      dqph_pkg::PH_LEN: begin
        if (b == 8'd0) begin
          finish    = 1'b1;
          reason    = dqph_pkg::STOP_ZERO;
          phase_nxt = dqph_pkg::PH_DONE;
        end else if (!len_ok) begin
          finish    = 1'b1;
          reason    = dqph_pkg::STOP_LONG;
          phase_nxt = dqph_pkg::PH_DONE;
        end else begin
          finish    = endp;
          reason    = lim ? dqph_pkg::STOP_LIMIT : dqph_pkg::STOP_END;
          phase_nxt = dqph_pkg::PH_LABEL;
          left_nxt  = b[dqph_pkg::LEFT_W-1:0];
        end
      end
      dqph_pkg::PH_LABEL: begin
        finish   = ((left_dec == '0) && lim) || endp;
        reason   = lim ? dqph_pkg::STOP_LIMIT : dqph_pkg::STOP_END;
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt = lim ? dqph_pkg::PH_DONE : dqph_pkg::PH_LEN;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase

    chars_nxt  = chars1;
    labels_nxt = labels1;
    hash_nxt   = hash1;
    frozen_nxt = frozen1;

    // any packet end brings everything back to the reset values
    if (endp) begin
      phase_nxt  = dqph_pkg::PH_LEN;
      left_nxt   = '0;
      chars_nxt  = '0;
      labels_nxt = '0;
      hash_nxt   = dqph_pkg::HASH_SEED;
      frozen_nxt = 1'b0;
    end

    ci.item_kind   = dqph_pkg::KIND_CHAR;
    ci.name_char   = c;
    ci.name_length = 8'd0;
    ci.name_hash   = '0;
    ci.stop_reason = dqph_pkg::STOP_ZERO;
    ci.last_of_run = !finish;

    si.item_kind   = dqph_pkg::KIND_SUMMARY;
    si.name_char   = 8'd0;
    si.name_length = 8'(chars1);
    si.name_hash   = hash1;
    si.stop_reason = reason;
    si.last_of_run = 1'b1;

    res.n  = 2'd0;
    res.r0 = ci;
    res.r1 = si;
    if (fire) begin
      if (emitted && finish) begin
        res.n = 2'd2;
      end else if (emitted) begin
        res.n = 2'd1;
      end else if (finish) begin
        res.n  = 2'd1;
        res.r0 = si;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= dqph_pkg::PH_LEN;
      left_r   <= '0;
      chars_r  <= '0;
      labels_r <= '0;
      hash_r   <= dqph_pkg::HASH_SEED;
      frozen_r <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      left_r   <= left_nxt;
      chars_r  <= chars_nxt;
      labels_r <= labels_nxt;
      hash_r   <= hash_nxt;
      frozen_r <= frozen_nxt;
    end
  end

endmodule

### design/dqph_rfifo.sv
// dqph_rfifo: small result queue, takes up to two results a cycle and
// hands out one; depends on dqph_pkg

module dqph_rfifo (
  input  logic                clk,
  input  logic                rst_n,
  input  dqph_pkg::res_pair_t push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output dqph_pkg::out_item_t out_data
);

  dqph_pkg::out_item_t          mem_r [dqph_pkg::FIFO_DEPTH];
  logic [dqph_pkg::PTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [dqph_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         pop;
  logic [dqph_pkg::PTR_W-1:0]   wr1;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid && !out_stall;
  // room for a whole byte's worth of results, from registered state only
  assign room      = (cnt_r <= dqph_pkg::CNT_W'(dqph_pkg::FIFO_DEPTH - 2));
  assign wr1       = wr_r + dqph_pkg::PTR_W'(1);

  always_comb begin
    wr_nxt  = wr_r + dqph_pkg::PTR_W'(push.n);
    rd_nxt  = rd_r + dqph_pkg::PTR_W'(pop);
    cnt_nxt = cnt_r + dqph_pkg::CNT_W'(push.n) - dqph_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### design/dns_qname_parse_hash.sv
// dns_qname_parse_hash: top level, input register, parser core and result queue
// depends on dqph_pkg, dqph_core and dqph_rfifo
//
// usage:
//   in_*  : one question-section byte per request (the bytes after the 12-byte
//           header), with packet_end set on the last byte of the packet
//   out_* : name characters (dots included) and one summary per name carrying
//           length, djb2 hash and stop reason; last_of_run marks the final
//           result made by a byte
//   a byte waits in the input register until the result queue has room, is
//   decoded and written into the result queue, and its first result then
//   shows on out_valid once the results ahead of it have left the queue
//   one byte is taken every cycle while the four-entry result queue has room
//   for two; a byte makes at most two results, so sustained throughput is one
//   result per cycle while out_stall is low, set by the single output port
//   out_stall holds the queue head; the queue fills and then in_stall rises
//   reset (rst_n low, synchronous) empties the queue and puts the parser in
//   its expect-length state with the hash seeded to 5381

module dns_qname_parse_hash (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dqph_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dqph_pkg::out_item_t out_data
);

  logic                 in_vld_r, in_vld_nxt;
  dqph_pkg::in_item_t   in_item_r;
  logic                 room, take, load;
  dqph_pkg::res_pair_t  res;

  assign take     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign load     = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (load) begin
      in_vld_nxt = 1'b1;
    end else if (take) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_item_r <= in_data;
    end
  end

  dqph_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (take),
    .item  (in_item_r),
    .res   (res)
  );

  dqph_rfifo u_rfifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
